>>> rtl/rotary_encoder_step_detector_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rotary encoder step detector.
// ---------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_STEP_DETECTOR_DEFINES_SVH
`define ROTARY_ENCODER_STEP_DETECTOR_DEFINES_SVH

// Concurrent check that is switched off while reset is asserted.
`define RENC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define RENC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/rencstep_pkg.sv
// ---------------------------------------------------------------------------
// rencstep_pkg
// Shared types and constants of the rotary encoder step detector.
// ---------------------------------------------------------------------------
`default_nettype none

package rencstep_pkg;

    // Depth of the pin history and the change count needed before a report.
    localparam int unsigned HIST_DEPTH  = 5;
    localparam logic [7:0]  MIN_CHANGES = 8'd4;

    // Reset value of the lockout register.
    localparam logic [7:0]  LOCKOUT_RESET = 8'd100;

    // Register index of the lockout register on the configuration port.
    localparam logic        REG_LOCKOUT = 1'b0;

    // Encoder pin codes.
    typedef enum logic [1:0] {
        PINS_00 = 2'd0,
        PINS_01 = 2'd1,
        PINS_10 = 2'd2,
        PINS_11 = 2'd3
    } t_pins;

    // Step report codes.
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_DIR_A = 2'd1,
        EV_DIR_B = 2'd2
    } t_step_event;

    // Control from the top level to the decode core.
    typedef struct packed {
        logic       fire;
        logic [1:0] pins;
        logic [7:0] lockout_ticks;
    } t_core_req;

endpackage

`default_nettype wire

>>> rtl/rotary_encoder_step_detector.sv
// ---------------------------------------------------------------------------
// rotary_encoder_step_detector
// Input channel: one request per encoder tick carries the two sampled pins on
// i_enc_pins, qualified by i_in_valid and held back by o_in_stall.
// Output channel: one request per input request carries o_step_event
// (none, direction A or direction B), qualified by o_out_valid and held back
// by i_out_stall.
// A request is accepted into the input register, decoded as it leaves it, and
// its result is loaded into the output register, which drives o_out_valid.
// Throughput is one request per cycle while the receiver does not stall; the
// combinational compare and shift of the history allows this.
// When the receiver stalls, the output register holds its request and the
// input register still takes one more; beyond that o_in_stall rises.
// Reset clears the history, change count and lockout, empties both registers
// and loads the lockout register with 100.
// The lockout register is written through the APB-style port at byte
// address 0 and reads back on prdata.
// ---------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_step_detector
    import rencstep_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_enc_pins,
    // Output channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_step_event,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        r_in_valid;
    logic [1:0]  r_in_pins;
    logic        r_out_valid;
    logic [1:0]  r_out_event;
    logic [7:0]  r_lockout_ticks;
    logic        advance;
    logic        in_accept;
    t_core_req   core_req;
    t_step_event core_event;

    // The output stage can take a new result when empty or being drained.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Configuration register and read-back.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LOCKOUT) ? {24'd0, r_lockout_ticks} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout_ticks <= LOCKOUT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_LOCKOUT)) begin
            r_lockout_ticks <= pwdata[7:0];
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance || !r_in_valid) begin
            r_in_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_pins <= i_enc_pins;
        end
    end

    // Decode core works on the request as it leaves the input register.
    assign core_req.fire          = r_in_valid && advance;
    assign core_req.pins          = r_in_pins;
    assign core_req.lockout_ticks = r_lockout_ticks;

    rencstep_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (core_req),
        .o_event (core_event)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_req.fire) begin
            r_out_event <= core_event;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_step_event = r_out_event;

endmodule

`default_nettype wire

>>> rtl/rencstep_core.sv
// ---------------------------------------------------------------------------
// rencstep_core
// Holds the pin history, change count and lockout, and decodes steps.
// ---------------------------------------------------------------------------
`default_nettype none

module rencstep_core
    import rencstep_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_core_req   i_req,
    output t_step_event      o_event
);

    logic [1:0] r_hist [HIST_DEPTH];
    logic [1:0] n_hist [HIST_DEPTH];
    logic [7:0] r_count;
    logic [7:0] n_count;
    logic [7:0] r_lockout_left;
    logic [7:0] n_lockout_left;
    logic [7:0] count_inc;
    logic       changed;
    logic       dir_a;
    logic       dir_b;

    // The new history entries one to four are the old entries zero to three.
    assign changed   = (i_req.pins != r_hist[0]);
    assign count_inc = r_count + 8'd1;
    assign dir_a = (r_hist[0] == PINS_10) && (r_hist[1] == PINS_00) &&
                   (r_hist[2] == PINS_01) && (r_hist[3] == PINS_11);
    assign dir_b = (r_hist[0] == PINS_01) && (r_hist[1] == PINS_00) &&
                   (r_hist[2] == PINS_10) && (r_hist[3] == PINS_11);

    // Next state and report for the request in hand.
    always_comb begin
        n_hist         = r_hist;
        n_count        = r_count;
        n_lockout_left = r_lockout_left;
        o_event        = EV_NONE;
        if (i_req.fire) begin
            if (r_lockout_left != 8'd0) begin
                n_lockout_left = r_lockout_left - 8'd1;
            end else if (changed) begin
                for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                    n_hist[i] = r_hist[i - 1];
                end
                n_hist[0] = i_req.pins;
                n_count   = count_inc;
                if ((count_inc >= MIN_CHANGES) && (i_req.pins == PINS_11)) begin
                    if (dir_a) begin
                        o_event = EV_DIR_A;
                    end else if (dir_b) begin
                        o_event = EV_DIR_B;
                    end
                    if (dir_a || dir_b) begin
                        n_count        = 8'd0;
                        n_lockout_left = i_req.lockout_ticks;
                    end
                end
            end
        end
    end

    // Decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= PINS_00;
            end
            r_count        <= 8'd0;
            r_lockout_left <= 8'd0;
        end else begin
            r_hist         <= n_hist;
            r_count        <= n_count;
            r_lockout_left <= n_lockout_left;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rencstep_checker.sv
// ---------------------------------------------------------------------------
// rencstep_checker
// Port-level checks on the rotary encoder step detector.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rotary_encoder_step_detector_defines.svh"

module rencstep_checker
    import rencstep_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  o_step_event
);

    logic held;
    logic code_ok;
    logic step_taken;
    logic step_shown;

    // Output channel conditions used by the checks below.
    assign held       = o_out_valid && i_out_stall;
    assign code_ok    = (o_step_event == EV_NONE) || (o_step_event == EV_DIR_A) ||
                        (o_step_event == EV_DIR_B);
    assign step_shown = o_out_valid && (o_step_event != EV_NONE);
    assign step_taken = step_shown && !i_out_stall;

    // Reset empties the output stage.
    `RENC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // A stalled result is held unchanged.
    `RENC_ASSERT(a_out_hold, held |=> o_out_valid && $stable(o_step_event), "result moved")

    // Only defined report codes appear.
    `RENC_ASSERT(a_event_code, o_out_valid |-> code_ok, "undefined step code")

    // A report clears the change count, so the very next result cannot be a report.
    `RENC_ASSERT(a_no_double_step, step_taken |=> !step_shown, "two steps in a row")

endmodule

bind rotary_encoder_step_detector rencstep_checker u_checker (.*);

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Rotary encoder step detector testbench
// Drives encoder pin requests through the valid/stall input channel and
// predicts every step report with a cycle-free model of the history, change
// counter and lockout. Results are checked in order against the stored
// predictions. Covers both directions, lockout, unchanged samples and counter
// wrap, followed by random rotation traffic under several lockout settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import rencstep_pkg::*;

    // Cycles without any accepted request before the run is abandoned.
    localparam int IDLE_LIMIT = 2000;

    // Byte addresses on the configuration port.
    localparam logic [2:0] ADDR_LOCKOUT = {REG_LOCKOUT, 2'b00};
    localparam logic [2:0] ADDR_UNUSED  = 3'd4;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    logic [1:0]  enc_pins = PINS_00;
    logic        out_stall = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = ADDR_LOCKOUT;
    logic [31:0] pwdata   = 32'h0;

    wire         in_stall;
    wire         out_valid;
    wire [1:0]   step_event;
    wire [31:0]  prdata;
    wire         pready;

    rotary_encoder_step_detector dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_enc_pins   (enc_pins),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_step_event (step_event),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Predicted decoder state and its copy of the lockout register.
    logic [1:0]  pin_hist [HIST_DEPTH];
    logic [7:0]  chg_count;
    logic [7:0]  lock_left;
    logic [7:0]  lockout_cfg;

    t_step_event expected_events [$];
    int          errors = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;

    // Receiver stall pattern.
    int          stall_mode = 0;
    int          stall_left = 0;

    // Random rotation walk: the forward direction of this cycle is direction A.
    logic [1:0]  rot_cycle [4] = '{PINS_11, PINS_01, PINS_00, PINS_10};
    int          rot_pos = 0;
    int          rot_dir = 1;

    // Clock.
    initial begin
        forever #1 clk = ~clk;
    end

    // Advance the predicted state by one tick and return its step report.
    function automatic t_step_event predict_step(input logic [1:0] pins);
        t_step_event ev;
        ev = EV_NONE;
        if (lock_left != 8'd0) begin
            lock_left = lock_left - 8'd1;
        end else if (pins != pin_hist[0]) begin
            for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                pin_hist[i] = pin_hist[i - 1];
            end
            pin_hist[0] = pins;
            chg_count = chg_count + 8'd1;
            if (chg_count >= MIN_CHANGES && pin_hist[0] == PINS_11) begin
                if (pin_hist[1] == PINS_10 && pin_hist[2] == PINS_00 &&
                    pin_hist[3] == PINS_01 && pin_hist[4] == PINS_11) begin
                    ev = EV_DIR_A;
                end else if (pin_hist[1] == PINS_01 && pin_hist[2] == PINS_00 &&
                             pin_hist[3] == PINS_10 && pin_hist[4] == PINS_11) begin
                    ev = EV_DIR_B;
                end
                if (ev != EV_NONE) begin
                    chg_count = 8'd0;
                    lock_left = lockout_cfg;
                end
            end
        end
        return ev;
    endfunction

    // Send one pin request, at times idling between bursts, and record its prediction.
    task automatic send_tick(input logic [1:0] pins);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        enc_pins <= pins;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        expected_events.push_back(predict_step(pins));
    endtask

    // Stop sending and wait until every predicted report has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_events.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // Only register index zero exists; other writes are dropped.
        if (addr == ADDR_LOCKOUT) begin
            lockout_cfg = data[7:0];
        end
    endtask

    // Read the lockout register back and compare with the predicted copy.
    task automatic check_lockout_readback();
        logic [31:0] data;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_LOCKOUT;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (data !== {24'h0, lockout_cfg}) begin
            $error("lockout_ticks: expected %0d, actual %0d", lockout_cfg, data);
            errors++;
        end
    endtask

    // Change the lockout while idle, with junk in the unused upper data bits.
    task automatic set_lockout(input logic [7:0] value);
        logic [31:0] junk;
        junk = $urandom();
        drain();
        apb_write(ADDR_LOCKOUT, {junk[31:8], value});
        check_lockout_readback();
    endtask

    // Next pin value of a rotation walk with repeats, reversals and noise.
    function automatic logic [1:0] next_rotation_pins();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return 2'($urandom_range(0, 3));
        end
        if (r < 16) begin
            return rot_cycle[rot_pos];
        end
        if (r < 20) begin
            rot_dir = -rot_dir;
        end
        rot_pos = (rot_pos + rot_dir + 4) % 4;
        return rot_cycle[rot_pos];
    endfunction

    // Reset value of the register, and a sample equal to the reset history.
    task automatic test_reset_state();
        check_lockout_readback();
        send_tick(PINS_00);
    endtask

    // A write outside the register map is ignored; upper data bits are dropped.
    task automatic test_register_access();
        drain();
        apb_write(ADDR_UNUSED, 32'hFFFF_FF07);
        check_lockout_readback();
        set_lockout(8'd3);
    endtask

    // Both directions, locked ticks, an unchanged sample and a zero lockout.
    task automatic test_direction_steps();
        send_tick(PINS_11);
        send_tick(PINS_01);
        send_tick(PINS_00);
        send_tick(PINS_10);
        send_tick(PINS_11);
        // Three ticks ignored under lockout.
        send_tick(PINS_00);
        send_tick(PINS_01);
        send_tick(PINS_10);
        // Same as the newest history entry.
        send_tick(PINS_11);
        send_tick(PINS_10);
        send_tick(PINS_00);
        send_tick(PINS_01);
        send_tick(PINS_11);
        // The new lockout applies from the next report on; the running one still skips three ticks.
        set_lockout(8'd0);
        send_tick(PINS_01);
        send_tick(PINS_00);
        send_tick(PINS_10);
        send_tick(PINS_11);
        send_tick(PINS_11);
        send_tick(PINS_10);
        send_tick(PINS_00);
        send_tick(PINS_01);
        send_tick(PINS_11);
    endtask

    // Drive the change counter round past 255 so that a valid pattern is
    // rejected while the count is small again, then accepted later.
    task automatic test_counter_wrap();
        set_lockout(8'd0);
        while (chg_count != 8'd253 || lock_left != 8'd0) begin
            send_tick((pin_hist[0] == PINS_00) ? PINS_01 : PINS_00);
        end
        send_tick(PINS_11);
        repeat (2) begin
            send_tick(PINS_10);
            send_tick(PINS_00);
            send_tick(PINS_01);
            send_tick(PINS_11);
        end
    endtask

    // Random rotation traffic under a range of lockout settings.
    task automatic test_random_rotation();
        logic [7:0] settings [5];
        int         counts [5];
        settings = '{8'd0, 8'd255, 8'($urandom_range(1, 12)), LOCKOUT_RESET,
                     8'($urandom_range(0, 255))};
        counts   = '{180, 130, 170, 60, 120};
        for (int p = 0; p < 5; p++) begin
            set_lockout(settings[p]);
            repeat (counts[p]) send_tick(next_rotation_pins());
        end
    endtask

    // Receiver stall pattern: modes of random length, from none to long runs.
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: begin
                out_stall <= 1'b0;
            end
            1: begin
                out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                out_stall <= 1'($urandom_range(0, 1));
            end
            default: begin
                out_stall <= stall_left[3];
            end
        endcase
    end

    // Compare each accepted report with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_events.size() == 0) begin
                $error("step_event: unexpected report %0d", step_event);
                errors++;
            end else begin
                t_step_event exp_ev;
                exp_ev = expected_events.pop_front();
                if (step_event !== exp_ev) begin
                    $error("step_event: expected %0d, actual %0d", exp_ev, step_event);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which no request of any kind is accepted.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
            pin_hist[i] = PINS_00;
        end
        chg_count   = 8'd0;
        lock_left   = 8'd0;
        lockout_cfg = LOCKOUT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_register_access();
        test_direction_steps();
        test_counter_wrap();
        test_random_rotation();
        drain();

        if (errors == 0 && expected_events.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rencstep_pkg.sv
rtl/rencstep_core.sv
rtl/rotary_encoder_step_detector.sv
rtl/rencstep_checker.sv
verif/testbench.sv
